// File: rtl/assert_macros.svh
// assertion macros for the filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define SWMF_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion on the block clock and reset
`define SWMF_ASSERT(lbl, prop, msg) \
  `SWMF_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: rtl/swmf_pkg.sv
// types, constants and codes of the sliding window filter
`default_nettype none

package swmf_pkg;

  localparam int WINDOW      = 3;
  localparam int SAMPLE_BITS = 16;
  localparam int FIELD_BITS  = 16;

  localparam int MEDIAN_RANK = WINDOW / 2;
  localparam int RANK_BITS   = $clog2(WINDOW + 1);
  localparam int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW + 1);

  // mean and blend both divide by twice the window
  localparam int DIVISOR     = 2 * WINDOW;
  localparam int NUM_BITS    = SAMPLE_BITS + $clog2(DIVISOR + 1);
  localparam int RECIP_SHIFT = NUM_BITS + $clog2(DIVISOR);
  localparam int RECIP_BITS  = NUM_BITS + 2;
  localparam int PROD_BITS   = NUM_BITS + RECIP_BITS;
  localparam logic [RECIP_BITS-1:0] RECIP_MULT =
    RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [WINDOW-1:0]   window_t;
  typedef logic [SUM_BITS-1:0]    sum_t;
  typedef logic [NUM_BITS-1:0]    num_t;

  typedef enum logic [1:0] {
    MODE_MEAN   = 2'd0,
    MODE_MEDIAN = 2'd1,
    MODE_BLEND  = 2'd2
  } filter_mode_e;

  localparam filter_mode_e MODE_RESET = MODE_BLEND;

  typedef struct packed {
    logic advance;
    logic valid;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/swmf_cell.sv
// one window cell: holds a sample, shifts it on, and ranks it against the window
`default_nettype none

module swmf_cell
  import swmf_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    shift_i,
  input  wire sample_t sample_i,
  input  wire window_t window_i,
  output sample_t      value_o,
  output logic         median_o
);

  sample_t value_q, value_d;
  logic [WINDOW-1:0] lt_vec, le_vec;
  logic [RANK_BITS-1:0] lt_cnt, le_cnt;

  assign value_d = shift_i ? sample_i : value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else begin
      value_q <= value_d;
    end
  end

  // strictly below and at-or-below counts over the whole window, self included
  always_comb begin
    for (int k = 0; k < WINDOW; k++) begin
      lt_vec[k] = window_i[k] <  value_q;
      le_vec[k] = window_i[k] <= value_q;
    end
  end

  assign lt_cnt = RANK_BITS'($countones(lt_vec));
  assign le_cnt = RANK_BITS'($countones(le_vec));

  // the median position falls inside this cell's run of equal values
  assign median_o = (lt_cnt <= RANK_BITS'(MEDIAN_RANK)) &&
                    (le_cnt >  RANK_BITS'(MEDIAN_RANK));
  assign value_o  = value_q;

endmodule

`default_nettype wire

// File: rtl/swmf_blend.sv
// mode select, numerator and reciprocal divide stages
`default_nettype none

module swmf_blend
  import swmf_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire pipe_ctrl_t   ctrl_i,
  input  wire filter_mode_e mode_i,
  input  wire sample_t      median_i,
  input  wire sum_t         sum_i,
  output logic              valid_o,
  output sample_t           result_o
);

  logic     v3_q, v3_d;
  num_t     num_q, num_d;
  sample_t  med3_q, med3_d;
  logic     pick_q, pick_d;
  logic     vo_q, vo_d;
  sample_t  res_q, res_d;
  logic [PROD_BITS-1:0] prod_c;

  // numerator over twice the window
  always_comb begin
    pick_d = 1'b0;
    case (mode_i)
      MODE_MEAN:   num_d = NUM_BITS'(sum_i) << 1;
      MODE_MEDIAN: begin
        num_d  = NUM_BITS'(sum_i) << 1;
        pick_d = 1'b1;
      end
      default:     num_d = NUM_BITS'(NUM_BITS'(median_i) * NUM_BITS'(WINDOW)) +
                           NUM_BITS'(sum_i);
    endcase
  end

  assign v3_d   = ctrl_i.advance ? ctrl_i.valid : v3_q;
  assign med3_d = median_i;

  assign prod_c = PROD_BITS'(num_q) * PROD_BITS'(RECIP_MULT);
  assign vo_d   = ctrl_i.advance ? v3_q : vo_q;
  assign res_d  = pick_q ? med3_q : prod_c[RECIP_SHIFT +: SAMPLE_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v3_q <= v3_d;
      vo_q <= vo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      num_q  <= num_d;
      med3_q <= med3_d;
      pick_q <= pick_d;
      res_q  <= res_d;
    end
  end

  assign valid_o  = vo_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

// File: rtl/sliding_window_mean_median_filter_core.sv
// top level of the sliding window mean and median filter
`default_nettype none

// Sliding window filter over the last WINDOW samples (three by default).
// Every accepted sample word shifts into a row of cells, the oldest drops
// out, and one filtered word comes out per sample: the mean, the median or
// the floored average of both, as chosen by the mode register (reset value
// blend, code three behaves as blend). The window starts out full of zeros,
// so early results include them. One word is taken every clock cycle while
// the output is not stalled. The filtered word is registered in turn by the
// cell row, which takes the word at the accepting edge, then by the median
// rank stage, the numerator stage and the reciprocal multiplier stage.
// A stalled output freezes the whole pipeline and the input stalls with it.
// The mode register is written with cfg_we_i and must only change while no
// word is in flight.
module sliding_window_mean_median_filter_core
  import swmf_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_wdata_i,
  input  wire logic                  sample_valid_i,
  output logic                       sample_stall_o,
  input  wire logic [FIELD_BITS-1:0] sample_i,
  output logic                       filtered_valid_o,
  input  wire logic                  filtered_stall_i,
  output logic [FIELD_BITS-1:0]      filtered_o
);

  `include "assert_macros.svh"

  filter_mode_e mode_q, mode_d;

  logic advance_c, accept_c;
  logic v1_q, v1_d;
  logic v2_q, v2_d;
  sum_t sum_q, sum_d;
  sum_t sum2_q;
  sample_t med2_q, med_c;
  sample_t new_c;

  window_t window_c;
  sample_t [WINDOW-1:0] chain_in_c;
  logic [WINDOW-1:0] hit_vec;

  pipe_ctrl_t blend_ctrl;
  logic out_valid_c;
  sample_t result_c;

  // mode register
  assign mode_d = cfg_we_i ? filter_mode_e'(cfg_wdata_i) : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
    end else begin
      mode_q <= mode_d;
    end
  end

  // pipeline moves unless a finished word is held by the consumer
  assign advance_c      = !(out_valid_c && filtered_stall_i);
  assign sample_stall_o = !advance_c;
  assign accept_c       = sample_valid_i && advance_c;
  assign new_c          = sample_t'(sample_i);

  // cell row: cell zero takes the new word, the others take their neighbour
  assign chain_in_c[0] = new_c;
  for (genvar k = 1; k < WINDOW; k++) begin : g_link
    assign chain_in_c[k] = window_c[k-1];
  end

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    swmf_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (accept_c),
      .sample_i (chain_in_c[k]),
      .window_i (window_c),
      .value_o  (window_c[k]),
      .median_o (hit_vec[k])
    );
  end

  // running window sum, the last cell holds the word that drops out
  assign sum_d = accept_c ? sum_q + SUM_BITS'(new_c) - SUM_BITS'(window_c[WINDOW-1])
                          : sum_q;

  // equal hits carry equal values, so an and-or pick is safe
  always_comb begin
    med_c = '0;
    for (int k = 0; k < WINDOW; k++) begin
      med_c = med_c | (window_c[k] & {SAMPLE_BITS{hit_vec[k]}});
    end
  end

  assign v1_d = advance_c ? accept_c : v1_q;
  assign v2_d = advance_c ? v1_q : v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
    end else begin
      sum_q <= sum_d;
      v1_q  <= v1_d;
      v2_q  <= v2_d;
    end
  end

  // median and sum of the window as it stood after the word went in
  always_ff @(posedge clk_i) begin
    if (advance_c) begin
      med2_q <= med_c;
      sum2_q <= sum_q;
    end
  end

  assign blend_ctrl.advance = advance_c;
  assign blend_ctrl.valid   = v2_q;

  swmf_blend u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (blend_ctrl),
    .mode_i   (mode_q),
    .median_i (med2_q),
    .sum_i    (sum2_q),
    .valid_o  (out_valid_c),
    .result_o (result_c)
  );

  assign filtered_valid_o = out_valid_c;
  assign filtered_o       = FIELD_BITS'(result_c);

  `SWMF_ASSERT(a_median_found, hit_vec != '0, "no cell holds the window median")
  `SWMF_ASSERT(a_stall_held, sample_stall_o |-> (out_valid_c && filtered_stall_i), "stray stall")
  `SWMF_ASSERT(a_accept_fills, accept_c |=> v1_q, "accepted word lost before the rank stage")
  `SWMF_ASSERT(a_sum_idle, !accept_c |=> $stable(sum_q), "window sum moved without a new word")

endmodule

`default_nettype wire
